// ----- rtl/vn_pkg.sv -----
// Shared constants for the vector normalize pipeline.
package vn_pkg;

  // Unit components are signed Q1.14.
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned UNIT_W    = 16;
  // Quotient bits: the unit magnitude never exceeds 2^14.
  localparam int unsigned QUO_W     = FRAC_BITS + 1;

endpackage

// ----- rtl/vn_sumsq.sv -----
// Absolute values, squares and sum of squares over two register stages.
module vn_sumsq #(
  parameter int unsigned N = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [3*N-1:0]      in_comp,
  output logic                out_valid,
  output logic [2*N+1:0]      out_sum,
  output logic [3*N+2:0]      out_side
);
  import vn_pkg::*;

  logic [N-1:0]   mag     [3];
  logic [N-1:0]   mag_r   [3];
  logic [2*N-1:0] sq_r    [3];
  logic [2:0]     neg_r;
  logic           vld1_r;
  logic [N-1:0]   mag2_r  [3];
  logic [2:0]     neg2_r;
  logic [2*N+1:0] sum_r;
  logic           vld2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_comp[i*N + N-1]) begin
        mag[i] = N'(~in_comp[i*N +: N] + N'(1));
      end else begin
        mag[i] = in_comp[i*N +: N];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= mag[i];
        sq_r[i]   <= mag[i] * mag[i];
        mag2_r[i] <= mag_r[i];
        neg_r[i]  <= in_comp[i*N + N-1];
      end
      neg2_r <= neg_r;
      sum_r  <= (2*N+2)'(sq_r[0]) + (2*N+2)'(sq_r[1]) + (2*N+2)'(sq_r[2]);
    end
  end

  assign out_valid = vld2_r;
  assign out_sum   = sum_r;
  assign out_side  = {neg2_r, mag2_r[2], mag2_r[1], mag2_r[0]};

endmodule

// ----- rtl/vn_isqrt.sv -----
// Pipelined integer square root, one root bit per register stage.
module vn_isqrt #(
  parameter int unsigned N      = 16,
  parameter int unsigned SIDE_W = 51
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*N+1:0]    in_sum,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [N-1:0]      out_root,
  output logic [SIDE_W-1:0] out_side
);
  import vn_pkg::*;

  localparam int unsigned SW = 2*N + 2;

  logic [SW-1:0]     rem_r  [N+1];
  logic [N-1:0]      root_r [N+1];
  logic [SIDE_W-1:0] side_r [N+1];
  logic              vld_r  [N+1];

  assign rem_r[0]  = in_sum;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_valid;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned K = N - 1 - s;
    logic [SW-1:0] trial;
    assign trial = ((SW'(root_r[s]) << 1) + (SW'(1) << K)) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1] <= side_r[s];
        if (rem_r[s] >= trial) begin
          rem_r[s+1]  <= rem_r[s] - trial;
          root_r[s+1] <= root_r[s] | (N'(1) << K);
        end else begin
          rem_r[s+1]  <= rem_r[s];
          root_r[s+1] <= root_r[s];
        end
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_root  = root_r[N];
  assign out_side  = side_r[N];

endmodule

// ----- rtl/vn_divide.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage.
module vn_divide #(
  parameter int unsigned N      = 16,
  parameter int unsigned SIDE_W = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [3*N-1:0]        in_mag,
  input  logic [N-1:0]          in_len,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [3*vn_pkg::QUO_W-1:0] out_quo,
  output logic [N-1:0]          out_len,
  output logic [SIDE_W-1:0]     out_side
);
  import vn_pkg::*;

  localparam int unsigned RW = N + QUO_W;

  logic [RW-1:0]     rem_r  [QUO_W+1][3];
  logic [QUO_W-1:0]  quo_r  [QUO_W+1][3];
  logic [N-1:0]      len_r  [QUO_W+1];
  logic [SIDE_W-1:0] side_r [QUO_W+1];
  logic              vld_r  [QUO_W+1];

  for (genvar l = 0; l < 3; l++) begin : g_in
    assign rem_r[0][l] = RW'(in_mag[l*N +: N]) << FRAC_BITS;
    assign quo_r[0][l] = '0;
  end
  assign len_r[0]  = in_len;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_valid;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int unsigned J = QUO_W - 1 - s;
    logic [RW-1:0] dsr;
    assign dsr = RW'(len_r[s]) << J;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[s+1]  <= len_r[s];
        side_r[s+1] <= side_r[s];
        for (int l = 0; l < 3; l++) begin
          if (rem_r[s][l] >= dsr) begin
            rem_r[s+1][l] <= rem_r[s][l] - dsr;
            quo_r[s+1][l] <= quo_r[s][l] | (QUO_W'(1) << J);
          end else begin
            rem_r[s+1][l] <= rem_r[s][l];
            quo_r[s+1][l] <= quo_r[s][l];
          end
        end
      end
    end
  end

  assign out_valid = vld_r[QUO_W];
  assign out_quo   = {quo_r[QUO_W][2], quo_r[QUO_W][1], quo_r[QUO_W][0]};
  assign out_len   = len_r[QUO_W];
  assign out_side  = side_r[QUO_W];

endmodule

// ----- rtl/vec3_normalize.sv -----
// Top level of the 3-D vector normalize pipeline.
//
//   channel | dir | tdata fields (low bit first)              | tuser
//   --------+-----+--------------------------------------------+------------
//   in_     | in  | comp_x, comp_y, comp_z                     | -
//   out_    | out | unit_x, unit_y, unit_z, magnitude          | zero_vector
//
// One vector is accepted every cycle while the pipeline is not held. In order:
// two stages form the sum of squares, the square root settles one bit per
// stage (COMP_WIDTH stages), the three dividers settle one quotient bit per
// stage (15 stages) and one stage applies signs into the output register.
// Reset clears only the valid bits. When out_tready is low with a result
// waiting, the whole pipeline holds and in_tready drops; nothing is lost.
module vec3_normalize #(
  parameter int unsigned COMP_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // comp_x, comp_y, comp_z, zero padded to whole bytes
  input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // unit_x, unit_y, unit_z, magnitude, zero padded to whole bytes
  output logic [((3*vn_pkg::UNIT_W+COMP_WIDTH+7)/8)*8-1:0] out_tdata,
  // zero_vector
  output logic out_tuser
);
  import vn_pkg::*;

  localparam int unsigned N     = COMP_WIDTH;
  localparam int unsigned OUT_W = ((3*UNIT_W + COMP_WIDTH + 7) / 8) * 8;

  // The pipeline advances whenever the output register is free or drained.
  logic en;

  logic             sq_valid;
  logic [2*N+1:0]   sq_sum;
  logic [3*N+2:0]   sq_side;
  logic             rt_valid;
  logic [N-1:0]     rt_root;
  logic [3*N+2:0]   rt_side;
  logic             dv_valid;
  logic [3*QUO_W-1:0] dv_quo;
  logic [N-1:0]     dv_len;
  logic [2:0]       dv_neg;

  logic              out_valid_r;
  logic [UNIT_W-1:0] unit_r [3];
  logic [N-1:0]      mag_r;
  logic              zero_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  vn_sumsq #(.N(N)) u_sumsq (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid), .in_comp(in_tdata[3*N-1:0]),
    .out_valid(sq_valid), .out_sum(sq_sum), .out_side(sq_side)
  );

  vn_isqrt #(.N(N), .SIDE_W(3*N+3)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq_valid), .in_sum(sq_sum), .in_side(sq_side),
    .out_valid(rt_valid), .out_root(rt_root), .out_side(rt_side)
  );

  // Side data: the sign bits ride along; the magnitudes feed the dividers.
  vn_divide #(.N(N), .SIDE_W(3)) u_divide (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(rt_valid), .in_mag(rt_side[3*N-1:0]), .in_len(rt_root),
    .in_side(rt_side[3*N+2:3*N]),
    .out_valid(dv_valid), .out_quo(dv_quo), .out_len(dv_len), .out_side(dv_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  // A zero length forces all unit components to zero; the divider output
  // is meaningless in that case.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= dv_len;
      zero_r <= (dv_len == '0);
      for (int i = 0; i < 3; i++) begin
        if (dv_len == '0) begin
          unit_r[i] <= '0;
        end else if (dv_neg[i]) begin
          unit_r[i] <= UNIT_W'(~UNIT_W'(dv_quo[i*QUO_W +: QUO_W]) + UNIT_W'(1));
        end else begin
          unit_r[i] <= UNIT_W'(dv_quo[i*QUO_W +: QUO_W]);
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({mag_r, unit_r[2], unit_r[1], unit_r[0]});
  assign out_tuser  = zero_r;

  // A zero vector carries all-zero unit components.
  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3*UNIT_W-1:0] == '0)
    else $error("zero vector with nonzero unit components");

  // A nonzero result always carries a nonzero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3*UNIT_W +: COMP_WIDTH] != '0)
    else $error("nonzero vector with zero magnitude");

  // The input side is ready exactly when the output register can move.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("pipeline enable out of step with output register");

endmodule

// ----- bench/vec3_normalize_test.sv -----
// Self-checking bench for vec3_normalize: directed and random vectors against a behavioral model.
module vec3_normalize_test;
  import vn_pkg::*;

  localparam int unsigned CW = 16;
  localparam int unsigned IN_W = ((3*CW+7)/8)*8;
  localparam int unsigned OUT_W = ((3*UNIT_W+CW+7)/8)*8;
  localparam int unsigned LATENCY = CW + 18;

  typedef struct packed {
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] uz;
    logic [CW-1:0]     len;
    logic              zero;
  } norm_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  vec3_normalize #(.COMP_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  norm_t pending_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Integer square root, floor, by the classic bit-pair method.
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected length and unit vector for one input vector.
  function automatic norm_t normalize(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                      input logic [CW-1:0] z);
    logic [CW-1:0] c[3];
    logic [CW-1:0] a;
    logic [63:0] m[3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    logic [UNIT_W-1:0] u[3];
    norm_t r;
    c[0] = x; c[1] = y; c[2] = z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      // The most negative component wraps to its own full magnitude here.
      a = c[i][CW-1] ? (~c[i] + 1'b1) : c[i];
      m[i] = 64'(a);
      sum += m[i] * m[i];
    end
    len = root_floor(sum);
    r = '0;
    if (len == 0) begin
      r.zero = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FRAC_BITS) / len;
      if (c[i][CW-1]) q = (~q) + 1;
      u[i] = q[UNIT_W-1:0];
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
    r.len = len[CW-1:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Drives one vector and waits for it to be accepted. Valid stays high after
  // the accept so that a following item can go out back to back.
  task automatic send_vec(input logic [CW-1:0] x, input logic [CW-1:0] y,
                          input logic [CW-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= IN_W'({z, y, x});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(normalize(x, y, z));
    @(negedge clk);
  endtask

  // Receiver side: random stalls, with an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_recv) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    norm_t got;
    norm_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ux = out_tdata[UNIT_W-1:0];
      got.uy = out_tdata[2*UNIT_W-1:UNIT_W];
      got.uz = out_tdata[3*UNIT_W-1:2*UNIT_W];
      got.len = out_tdata[3*UNIT_W+CW-1:3*UNIT_W];
      got.zero = out_tuser;
      if (pending_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        want = pending_q.pop_front();
        if (got.ux !== want.ux) report("unit_x", 32'(got.ux), 32'(want.ux));
        if (got.uy !== want.uy) report("unit_y", 32'(got.uy), 32'(want.uy));
        if (got.uz !== want.uz) report("unit_z", 32'(got.uz), 32'(want.uz));
        if (got.len !== want.len) report("magnitude", 32'(got.len), 32'(want.len));
        if (got.zero !== want.zero) report("zero_vector", 32'(got.zero), 32'(want.zero));
      end
    end
  end

  // Directed rows; the expected column is checked only where marked.
  typedef struct {
    logic [CW-1:0] x, y, z;
    bit            typed;
    norm_t         res;
  } row_t;

  row_t dir_rows[$];

  function automatic row_t mk(input int x, input int y, input int z, input bit typed,
                              input int ux, input int uy, input int uz, input int len,
                              input bit zero);
    row_t r;
    r.x = x[CW-1:0]; r.y = y[CW-1:0]; r.z = z[CW-1:0];
    r.typed = typed;
    r.res.ux = ux[UNIT_W-1:0]; r.res.uy = uy[UNIT_W-1:0]; r.res.uz = uz[UNIT_W-1:0];
    r.res.len = len[CW-1:0]; r.res.zero = zero;
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return CW'($urandom_range(3));
      1: return -CW'($urandom_range(3));
      2: return {1'b1, {(CW-1){1'b0}}};
      3: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    row_t r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Zero vector, single-axis extremes, the most negative component and mixes.
    dir_rows.push_back(mk(0, 0, 0, 1, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk(256, 0, 0, 1, 16384, 0, 0, 256, 0));
    dir_rows.push_back(mk(0, -256, 0, 1, 0, -16384, 0, 256, 0));
    dir_rows.push_back(mk(0, 0, 1, 1, 0, 0, 16384, 1, 0));
    dir_rows.push_back(mk(-32768, 0, 0, 1, -16384, 0, 0, 32768, 0));
    dir_rows.push_back(mk(32767, 0, 0, 1, 16384, 0, 0, 32767, 0));
    dir_rows.push_back(mk(0, 0, -1, 1, 0, 0, -16384, 1, 0));
    dir_rows.push_back(mk(-32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(-32768, 32767, -32768, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 1, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(-1, -1, -1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(3, 4, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(-21845, 21845, -10923, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 0, -32768, 0, 0, 0, 0, 0, 0));

    // Typed rows are compared against the table as well as the model.
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.typed && normalize(r.x, r.y, r.z) !== r.res) begin
        report("directed row", i, 0);
      end
      send_vec(r.x, r.y, r.z);
    end
    wait_drained();

    random_phase(250, 0, 0);
    random_phase(200, 78, 0);
    random_phase(200, 0, 78);
    random_phase(150, 21, 21);

    // Long receiver hold-off while the sender keeps offering items.
    fork
      begin
        hold_recv = 1'b1;
        repeat (3 * LATENCY) @(negedge clk);
        hold_recv = 1'b0;
      end
      random_phase(100, 0, 0);
    join

    // The sender pauses until every result has come, then resumes.
    wait_drained();
    random_phase(100, 10, 10);

    wait_drained();
    repeat (LATENCY + 5) @(negedge clk);
    if (errors == 0) begin
      $display("vec3_normalize verification clean");
    end else begin
      $display("vec3_normalize verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("vec3_normalize verification failed");
    $finish;
  end

endmodule
